[src/bmpp_pkg.sv]
package bmpp_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = $clog2(MAX_DIM + 2);
	localparam int IDX_W   = 12;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_FMT_ERR = 2'd1;
	localparam logic [1:0] KIND_SIZE_ERR = 2'd2;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] row;
		logic             last_in_row;
		logic             last_pixel;
	} out_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[src/bmpp_front.sv]
module bmpp_front
	import bmpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_item_t  item,
	output logic      res_valid,
	output out_item_t res
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_PIXEL  = 2'd1;
	localparam logic [1:0] PH_PAD    = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam logic [5:0] POS_WIDTH  = 6'd21;
	localparam logic [5:0] POS_HEIGHT = 6'd25;
	localparam logic [5:0] POS_BPP    = 6'd29;
	localparam logic [5:0] POS_LAST   = 6'd53;

	localparam logic [15:0] BPP_24 = 16'd24;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [31:0] v);
		clamp_dim = (v > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM + 1) : v[DIM_W-1:0];
	endfunction

	logic [1:0]       phase_q, phase_d, phase_e;
	logic [5:0]       pos_q, pos_d, pos_e;
	logic [31:0]      fa_q, fa_d, fa_e;
	logic [DIM_W-1:0] width_q, width_d, width_e;
	logic [DIM_W-1:0] height_q, height_d, height_e;
	logic             bpp_ok_q, bpp_ok_d, bpp_ok_e;
	logic [IDX_W-1:0] col_q, col_d;
	logic [IDX_W-1:0] row_q, row_d;
	logic [1:0]       ch_q, ch_d;
	logic [1:0]       pad_q, pad_d;
	logic [7:0]       blue_q, blue_d;
	logic [7:0]       green_q, green_d;
	logic             lr, lp;

	// first_byte restarts the parser before this byte is consumed
	assign phase_e  = item.first_byte ? PH_HEADER : phase_q;
	assign pos_e    = item.first_byte ? 6'd0 : pos_q;
	assign fa_e     = item.first_byte ? 32'd0 : fa_q;
	assign width_e  = item.first_byte ? '0 : width_q;
	assign height_e = item.first_byte ? '0 : height_q;
	assign bpp_ok_e = item.first_byte ? 1'b0 : bpp_ok_q;

	assign lr = (DIM_W'(col_q) == width_q - DIM_W'(1));
	assign lp = lr && (DIM_W'(row_q) == height_q - DIM_W'(1));

	always_comb begin
		phase_d   = phase_e;
		pos_d     = pos_e;
		fa_d      = fa_e;
		width_d   = width_e;
		height_d  = height_e;
		bpp_ok_d  = bpp_ok_e;
		col_d     = col_q;
		row_d     = row_q;
		ch_d      = ch_q;
		pad_d     = pad_q;
		blue_d    = blue_q;
		green_d   = green_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_e)
			PH_HEADER: begin
				fa_d = {item.stream_byte, fa_e[31:8]};
				if (pos_e == POS_WIDTH) begin
					width_d = clamp_dim(fa_d);
				end else if (pos_e == POS_HEIGHT) begin
					height_d = clamp_dim(fa_d);
				end else if (pos_e == POS_BPP) begin
					bpp_ok_d = (fa_d[31:16] == BPP_24);
				end
				if (pos_e != POS_LAST) begin
					pos_d = pos_e + 6'd1;
				end else if (!bpp_ok_e) begin
					phase_d   = PH_DONE;
					res_valid = 1'b1;
					res.kind  = KIND_FMT_ERR;
				end else if (width_e > DIM_W'(MAX_DIM) || height_e > DIM_W'(MAX_DIM)) begin
					phase_d   = PH_DONE;
					res_valid = 1'b1;
					res.kind  = KIND_SIZE_ERR;
				end else if (width_e == '0 || height_e == '0) begin
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_PIXEL;
					col_d   = '0;
					row_d   = '0;
					ch_d    = 2'd0;
				end
			end
			PH_PIXEL: begin
				if (ch_q == 2'd0) begin
					blue_d = item.stream_byte;
					ch_d   = 2'd1;
				end else if (ch_q == 2'd1) begin
					green_d = item.stream_byte;
					ch_d    = 2'd2;
				end else begin
					ch_d            = 2'd0;
					res_valid       = 1'b1;
					res.kind        = KIND_PIXEL;
					res.red         = item.stream_byte;
					res.green       = green_q;
					res.blue        = blue_q;
					res.column      = col_q;
					res.row         = row_q;
					res.last_in_row = lr;
					res.last_pixel  = lp;
					if (lp) begin
						phase_d = PH_DONE;
					end else if (lr) begin
						col_d = '0;
						row_d = row_q + IDX_W'(1);
						pad_d = width_q[1:0];
						if (width_q[1:0] != 2'd0) begin
							phase_d = PH_PAD;
						end
					end else begin
						col_d = col_q + IDX_W'(1);
					end
				end
			end
			PH_PAD: begin
				pad_d = pad_q - 2'd1;
				if (pad_q <= 2'd1) begin
					pad_d   = 2'd0;
					phase_d = PH_PIXEL;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			fa_q     <= '0;
			width_q  <= '0;
			height_q <= '0;
			bpp_ok_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			ch_q     <= '0;
			pad_q    <= '0;
			blue_q   <= '0;
			green_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			fa_q     <= fa_d;
			width_q  <= width_d;
			height_q <= height_d;
			bpp_ok_q <= bpp_ok_d;
			col_q    <= col_d;
			row_q    <= row_d;
			ch_q     <= ch_d;
			pad_q    <= pad_d;
			blue_q   <= blue_d;
			green_q  <= green_d;
		end
	end

endmodule

[src/bmpp_queue.sv]
module bmpp_queue
	import bmpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	input  logic      pop,
	output out_item_t pop_data,
	output q_status_t status
);

	out_item_t       mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	assign status.full  = (count_q == Q_CW'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CW'(1);
			end
		end
	end

endmodule

[src/bmpp_back.sv]
module bmpp_back
	import bmpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_status,
	input  out_item_t q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      valid_q;
	out_item_t data_q;

	// refill the output register whenever it is empty or being drained
	assign q_pop     = !q_status.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_item  = data_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[src/bmp24_pixel_stream_parser_unit.sv]
// Streaming parser for uncompressed 24-bit BMP files. Each in_item transaction carries a byte of
// the file, at a sustained rate of one byte per clock cycle while in_ready is high; first_byte
// restarts parsing at header byte 0. After the 54-byte header the block checks bit depth (format
// error) and dimensions against MAX_DIM (size error), then emits one pixel transaction per
// blue/green/red triple with column, row and end-of-row/end-of-image flags, skipping row pad
// bytes. Results leave through a two-entry queue and then an output register before they show
// on out_item; the input stalls only while the queue is full, which happens only when the
// consumer holds the output register.
module bmp24_pixel_stream_parser_unit
	import bmpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      accept;
	logic      res_valid;
	out_item_t res;
	logic      push;
	logic      pop;
	out_item_t q_data;
	q_status_t q_status;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && res_valid;

	bmpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_item),
		.res_valid (res_valid),
		.res       (res)
	);

	bmpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.pop       (pop),
		.pop_data  (q_data),
		.status    (q_status)
	);

	bmpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_data    (q_data),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("result queue underflow");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.kind != KIND_PIXEL) |->
			(out_item.red == 8'd0 && out_item.green == 8'd0 && out_item.blue == 8'd0 &&
			 out_item.column == '0 && out_item.row == '0 &&
			 !out_item.last_in_row && !out_item.last_pixel))
		else $error("error result carries pixel data");

	a_last_pixel_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.last_pixel) |-> out_item.last_in_row)
		else $error("last pixel not at end of row");

endmodule

[tb/tb_bmp24_pixel_stream_parser_unit.sv]
`timescale 1ns / 1ps

module tb_bmp24_pixel_stream_parser_unit;
	import bmpp_pkg::*;

	localparam int HDR_LEN   = 54;
	localparam int WIDTH_END = 21;
	localparam int HEIGHT_END = 25;
	localparam int BPP_END   = 29;
	localparam int HDR_LAST  = HDR_LEN - 1;
	localparam int RAND_BYTES = 200;

	typedef enum logic [1:0] {PH_HDR, PH_PIX, PH_PAD, PH_IDLE} parse_phase_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	bmp24_pixel_stream_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser mirror
	parse_phase_e     ph;
	logic [5:0]       hdr_pos;
	logic [31:0]      hdr_field;
	logic [DIM_W-1:0] img_w, img_h;
	logic [IDX_W-1:0] col_cnt, row_cnt;
	logic [1:0]       chan;
	logic [1:0]       pad_left;
	logic [7:0]       blue_b, green_b;
	logic             depth_ok;

	in_item_t  byte_feed[$];
	out_item_t expected_px[$];
	out_item_t pred, want;
	int        err_count = 0;
	int        stim_bytes = 0;

	function automatic void clear_parser();
		ph        = PH_HDR;
		hdr_pos   = '0;
		hdr_field = '0;
		img_w     = '0;
		img_h     = '0;
		col_cnt   = '0;
		row_cnt   = '0;
		chan      = '0;
		pad_left  = '0;
		blue_b    = '0;
		green_b   = '0;
		depth_ok  = 1'b0;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [31:0] v);
		return (v > MAX_DIM) ? DIM_W'(MAX_DIM + 1) : v[DIM_W-1:0];
	endfunction

	function automatic bit parse_byte(input in_item_t it, output out_item_t res);
		logic lr, lp;
		res = '0;
		if (it.first_byte)
			clear_parser();
		case (ph)
			PH_HDR: begin
				hdr_field = {it.stream_byte, hdr_field[31:8]};
				if (hdr_pos == WIDTH_END)
					img_w = clamp_dim(hdr_field);
				else if (hdr_pos == HEIGHT_END)
					img_h = clamp_dim(hdr_field);
				else if (hdr_pos == BPP_END)
					depth_ok = (hdr_field[31:16] == 16'd24);
				if (hdr_pos < HDR_LAST) begin
					hdr_pos = hdr_pos + 1'b1;
					return 1'b0;
				end
				if (!depth_ok) begin
					ph = PH_IDLE;
					res.kind = KIND_FMT_ERR;
					return 1'b1;
				end
				if (img_w > MAX_DIM || img_h > MAX_DIM) begin
					ph = PH_IDLE;
					res.kind = KIND_SIZE_ERR;
					return 1'b1;
				end
				if (img_w == 0 || img_h == 0) begin
					ph = PH_IDLE;
					return 1'b0;
				end
				ph      = PH_PIX;
				col_cnt = '0;
				row_cnt = '0;
				chan    = '0;
				return 1'b0;
			end
			PH_PIX: begin
				if (chan == 2'd0) begin
					blue_b = it.stream_byte;
					chan   = 2'd1;
					return 1'b0;
				end
				if (chan == 2'd1) begin
					green_b = it.stream_byte;
					chan    = 2'd2;
					return 1'b0;
				end
				chan = 2'd0;
				lr = ({1'b0, col_cnt} == img_w - 1'b1);
				lp = lr && ({1'b0, row_cnt} == img_h - 1'b1);
				res.kind        = KIND_PIXEL;
				res.red         = it.stream_byte;
				res.green       = green_b;
				res.blue        = blue_b;
				res.column      = col_cnt;
				res.row         = row_cnt;
				res.last_in_row = lr;
				res.last_pixel  = lp;
				if (lp)
					ph = PH_IDLE;
				else if (lr) begin
					col_cnt  = '0;
					row_cnt  = row_cnt + 1'b1;
					pad_left = img_w[1:0];
					if (pad_left != 0)
						ph = PH_PAD;
				end else
					col_cnt = col_cnt + 1'b1;
				return 1'b1;
			end
			PH_PAD: begin
				if (pad_left != 0)
					pad_left = pad_left - 1'b1;
				if (pad_left == 0)
					ph = PH_PIX;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic string show(input out_item_t r);
		return $sformatf("kind=%0d rgb=%h/%h/%h col=%0d row=%0d lr=%0b lp=%0b",
			r.kind, r.red, r.green, r.blue, r.column, r.row, r.last_in_row, r.last_pixel);
	endfunction

	// fill < 0 gives random filler/pixel bytes, otherwise every such byte is fill
	task automatic queue_file(input logic [31:0] w, input logic [31:0] h,
			input logic [15:0] bpp, input bit mark_first, input int cut,
			input int tail, input int fill);
		logic [7:0] body[$];
		int         k, r, c, wi, hi;
		in_item_t   it;
		for (k = 0; k < HDR_LEN; k++)
			body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		for (k = 0; k < 4; k++) begin
			body[18 + k] = w[8*k +: 8];
			body[22 + k] = h[8*k +: 8];
		end
		body[28] = bpp[7:0];
		body[29] = bpp[15:8];
		if (bpp == 16'd24 && w != 0 && h != 0 && w <= MAX_DIM && h <= MAX_DIM) begin
			wi = int'(w);
			hi = int'(h);
			for (r = 0; r < hi; r++) begin
				for (c = 0; c < 3 * wi; c++)
					body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
				for (c = 0; c < wi % 4; c++)
					body.push_back(8'($urandom));
			end
		end
		for (k = 0; k < body.size() && (cut < 0 || k < cut); k++) begin
			it.stream_byte = body[k];
			it.first_byte  = mark_first && (k == 0);
			byte_feed.push_back(it);
			stim_bytes++;
		end
		for (k = 0; k < tail; k++) begin
			it.stream_byte = 8'($urandom);
			it.first_byte  = 1'b0;
			byte_feed.push_back(it);
			stim_bytes++;
		end
	endtask

	// sender
	int tx_wait, tx_burst;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			tx_wait  <= 0;
			tx_burst <= 0;
		end else if (!in_valid || in_ready) begin
			if (tx_wait != 0) begin
				in_valid <= 1'b0;
				tx_wait  <= tx_wait - 1;
			end else if (byte_feed.size() != 0) begin
				in_item  <= byte_feed.pop_front();
				in_valid <= 1'b1;
				if (tx_burst != 0) begin
					tx_burst <= tx_burst - 1;
					tx_wait  <= 0;
				end else if ($urandom_range(0, 31) == 0) begin
					tx_burst <= $urandom_range(20, 300);
					tx_wait  <= 0;
				end else
					tx_wait <= $urandom_range(0, 12);
			end else
				in_valid <= 1'b0;
		end
	end

	// long receiver hold-off so the result queue fills and the input stalls
	int cyc, hold_left, holds_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc        <= 0;
			hold_left  <= 0;
			holds_done <= 0;
		end else begin
			cyc <= cyc + 1;
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			else if (holds_done < 3 && out_valid &&
					cyc > (holds_done == 0 ? 2000 : holds_done == 1 ? 40000 : 100000)) begin
				hold_left  <= 300;
				holds_done <= holds_done + 1;
			end
		end
	end

	// receiver
	int rx_wait, rx_burst, rx_draw;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   <= 0;
			rx_burst  <= 0;
		end else if (out_valid && out_ready) begin
			if (rx_burst != 0) begin
				rx_burst <= rx_burst - 1;
				rx_draw = 0;
			end else if ($urandom_range(0, 31) == 0) begin
				rx_burst <= $urandom_range(20, 200);
				rx_draw = 0;
			end else
				rx_draw = $urandom_range(0, 12);
			rx_wait   <= rx_draw;
			out_ready <= (rx_draw == 0) && (hold_left == 0);
		end else if (rx_wait != 0) begin
			rx_wait   <= rx_wait - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= (hold_left == 0);
	end

	// prediction on input transactions, checking on output transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clear_parser();
		else begin
			if (in_valid && in_ready) begin
				if (parse_byte(in_item, pred))
					expected_px.push_back(pred);
			end
			if (out_valid && out_ready) begin
				if (expected_px.size() == 0) begin
					if (err_count < 10)
						$display("unexpected result: %s", show(out_item));
					err_count++;
				end else begin
					want = expected_px.pop_front();
					if (out_item !== want) begin
						if (err_count < 10)
							$display("mismatch: expected %s, got %s", show(want), show(out_item));
						err_count++;
					end
				end
			end
		end
	end

	initial begin
		#25_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int          sel, total, cut;
		logic [31:0] fw, fh, big;
		logic [15:0] bpp;

		// directed: right after reset without a first_byte mark
		queue_file(2, 2, 16'd24, 1'b0, -1, 3, -1);
		queue_file(3, 3, 16'd8, 1'b1, -1, 4, -1);             // bad depth
		queue_file(32'hFFFF_FFFF, 3, 16'd32, 1'b1, -1, 2, -1); // bad depth wins over size
		queue_file(2, 2, 16'h0118, 1'b1, -1, 0, -1);          // depth upper byte set
		queue_file(4097, 1, 16'd24, 1'b1, -1, 3, -1);         // just over the limit
		queue_file(2, 32'hFFFF_FFFE, 16'd24, 1'b1, -1, 0, -1); // top-down height
		queue_file(32'h0001_0000, 2, 16'd24, 1'b1, -1, 0, -1);
		queue_file(0, 5, 16'd24, 1'b1, -1, 10, -1);           // empty image
		queue_file(5, 0, 16'd24, 1'b1, -1, 10, -1);
		queue_file(1, 1, 16'd24, 1'b1, -1, 6, -1);
		queue_file(5, 3, 16'd24, 1'b1, -1, 2, -1);
		queue_file(6, 2, 16'd24, 1'b1, -1, 2, -1);
		queue_file(7, 2, 16'd24, 1'b1, -1, 2, -1);
		queue_file(4, 2, 16'd24, 1'b1, -1, 2, -1);
		queue_file(2, 1, 16'd24, 1'b1, -1, 1, 8'hFF);
		queue_file(2, 1, 16'd24, 1'b1, -1, 1, 8'h00);
		queue_file(3, 3, 16'd24, 1'b1, 20, 0, -1);            // cut inside header
		queue_file(3, 3, 16'd24, 1'b1, HDR_LEN + 10, 0, -1);  // cut inside row pad
		queue_file(3, 2, 16'd24, 1'b1, HDR_LEN + 10, 0, -1);  // cut inside row pad
		queue_file(MAX_DIM, 1, 16'd24, 1'b1, HDR_LEN + 12, 2, -1); // widest image, first pixels
		queue_file(1, MAX_DIM, 16'd24, 1'b1, HDR_LEN + 12, 2, -1); // tallest image, first rows
		queue_file(3, 2, 16'd24, 1'b1, -1, 0, -1);

		stim_bytes = 0;
		while (stim_bytes < RAND_BYTES) begin
			sel = $urandom_range(0, 99);
			fw  = $urandom_range(1, 9);
			fh  = $urandom_range(1, 6);
			if (sel < 70)
				queue_file(fw, fh, 16'd24, 1'b1, -1, $urandom_range(0, 6), -1);
			else if (sel < 78) begin
				bpp = 16'($urandom);
				if (bpp == 16'd24)
					bpp = 16'd25;
				if ($urandom_range(0, 1))
					fw = $urandom;
				queue_file(fw, fh, bpp, 1'b1, -1, $urandom_range(0, 4), -1);
			end else if (sel < 86) begin
				big = $urandom_range(0, 1) ? 32'($urandom_range(4097, 65535))
					: {1'b1, 31'($urandom)};
				if ($urandom_range(0, 1))
					fw = big;
				else
					fh = big;
				queue_file(fw, fh, 16'd24, 1'b1, -1, $urandom_range(0, 4), -1);
			end else if (sel < 90) begin
				if ($urandom_range(0, 1))
					fw = 0;
				else
					fh = 0;
				queue_file(fw, fh, 16'd24, 1'b1, -1, $urandom_range(0, 4), -1);
			end else if (sel < 97) begin
				total = HDR_LEN + int'(fh) * (3 * int'(fw) + int'(fw) % 4);
				cut = $urandom_range(1, total - 1);
				queue_file(fw, fh, 16'd24, 1'b1, cut, 0, -1);
			end else
				queue_file($urandom_range(10, 64), $urandom_range(1, 3), 16'd24, 1'b1, -1,
					$urandom_range(0, 6), -1);
		end

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_feed.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_px.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (err_count == 0 && expected_px.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
